[sv/chs_pkg.sv]
// Shared types and constants for the CHS disk transfer sequencer.
// Used by chs_div and chs_disk_transfer_sequencer; depends on nothing.
`default_nettype none

package chs_pkg;

  localparam int SECTOR_W = 28;   // linear sector width
  localparam int PCYL_W   = 13;   // heads (5b) * sectors per track (8b)
  localparam int COUNT_W  = 16;
  localparam int TOTAL_W  = 32;

  typedef enum logic [2:0] {
    K_PROGRAM  = 3'd0,
    K_MOVE     = 3'd1,
    K_DONE_OK  = 3'd2,
    K_DONE_ERR = 3'd3,
    K_REJECT   = 3'd4,
    K_STRAY    = 3'd5,
    K_ACCEPT   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    R_UNIT0_PRESENT = 3'd0,
    R_UNIT0_HEADS   = 3'd1,
    R_UNIT0_SPT     = 3'd2,
    R_UNIT1_PRESENT = 3'd3,
    R_UNIT1_HEADS   = 3'd4,
    R_UNIT1_SPT     = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_NEXT,
    S_MUL,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV2_WAIT,
    S_PROG,
    S_MOVE
  } state_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           burst_count;
    logic [7:0]           sector_number;
    logic [15:0]          cylinder;
    logic [3:0]           head;
    logic                 unit_out;
    logic                 write_command;
    logic [SECTOR_W-1:0]  sector_address;
    logic [TOTAL_W-1:0]   stray_count;
    logic [TOTAL_W-1:0]   soft_error_count;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

[sv/chs_div.sv]
// Serial restoring divider: one quotient bit per cycle, SECTOR_W quotient bits per division.
// Depends on chs_pkg for widths.
`default_nettype none

module chs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [chs_pkg::SECTOR_W-1:0]  dividend,
  input  wire logic [chs_pkg::PCYL_W-1:0]    divisor,
  output logic                               busy,
  output logic                               done,
  output logic [chs_pkg::SECTOR_W-1:0]       quotient,
  output logic [chs_pkg::PCYL_W-1:0]         remainder
);

  localparam int CNT_W = $clog2(chs_pkg::SECTOR_W + 1);

  logic [CNT_W-1:0]             cnt;
  logic [chs_pkg::PCYL_W-1:0]   dsr;
  logic [chs_pkg::PCYL_W:0]     trial;
  logic                         ge;

  assign trial = {remainder, quotient[chs_pkg::SECTOR_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(chs_pkg::SECTOR_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[chs_pkg::SECTOR_W-2:0], ge};
      remainder <= ge ? chs_pkg::PCYL_W'(trial - {1'b0, dsr})
                      : trial[chs_pkg::PCYL_W-1:0];
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while busy");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && dsr != '0 |-> remainder < dsr)
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

[sv/chs_disk_transfer_sequencer.sv]
// Top level of the CHS disk transfer sequencer: control sequencer and result register.
// Depends on chs_pkg and chs_div.
`default_nettype none

// A start or interrupt is taken only while the sequencer is idle and yields one to three
// results through a single output register. Items that do not program a burst go from the
// decide state back to idle, by way of the next state when the transfer ends with done ok,
// and wait in those states while the output side is not free. Programming a burst runs two
// divisions on the shared serial divider (sector by sectors-per-cylinder, then remainder
// by sectors per track), so a start or a burst-ending interrupt passes the multiply and both
// division states before its program result; on a write a move result follows it.
module chs_disk_transfer_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [7:0]                    cfg_data,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic                          is_write,
  input  wire logic                          drive,
  input  wire logic [chs_pkg::SECTOR_W-1:0]  start_sector,
  input  wire logic [chs_pkg::COUNT_W-1:0]   sector_total,
  input  wire logic                          status_busy,
  input  wire logic                          status_error,
  input  wire logic                          status_ecc,
  input  wire logic                          status_drq,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         kind,
  output logic [7:0]                         burst_count,
  output logic [7:0]                         sector_number,
  output logic [15:0]                        cylinder,
  output logic [3:0]                         head,
  output logic                               unit_out,
  output logic                               write_command,
  output logic [chs_pkg::SECTOR_W-1:0]       sector_address,
  output logic [chs_pkg::TOTAL_W-1:0]        stray_count,
  output logic [chs_pkg::TOTAL_W-1:0]        soft_error_count,
  output logic                               last
);

  // geometry registers
  logic [1:0]       present;
  logic [4:0]       heads   [2];
  logic [7:0]       spt_cfg [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      heads[0]   <= 5'd1;
      heads[1]   <= 5'd1;
      spt_cfg[0] <= 8'd1;
      spt_cfg[1] <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        chs_pkg::R_UNIT0_PRESENT: present[0]  <= cfg_data[0];
        chs_pkg::R_UNIT0_HEADS:   heads[0]    <= cfg_data[4:0];
        chs_pkg::R_UNIT0_SPT:     spt_cfg[0]  <= cfg_data;
        chs_pkg::R_UNIT1_PRESENT: present[1]  <= cfg_data[0];
        chs_pkg::R_UNIT1_HEADS:   heads[1]    <= cfg_data[4:0];
        chs_pkg::R_UNIT1_SPT:     spt_cfg[1]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  chs_pkg::state_t                state, state_next;
  logic                           active, active_next;
  logic                           act_unit, act_unit_next;
  logic                           act_write, act_write_next;
  logic [chs_pkg::SECTOR_W-1:0]   cur_sector, cur_sector_next;
  logic [chs_pkg::COUNT_W-1:0]    sectors_left, sectors_left_next;
  logic [7:0]                     burst_left, burst_left_next;
  logic [chs_pkg::TOTAL_W-1:0]    stray_total, stray_total_next;
  logic [chs_pkg::TOTAL_W-1:0]    soft_total, soft_total_next;

  // latched input item
  logic                           r_action, r_write, r_drive;
  logic [chs_pkg::SECTOR_W-1:0]   r_start;
  logic [chs_pkg::COUNT_W-1:0]    r_total;
  logic                           r_busy, r_err, r_ecc, r_drq;

  // geometry work registers
  logic [chs_pkg::PCYL_W-1:0]     per_cyl, per_cyl_next;
  logic [7:0]                     spt_q, spt_q_next;
  logic [15:0]                    cyl_q, cyl_q_next;
  logic [3:0]                     trk_q, trk_q_next;
  logic [7:0]                     rem_q, rem_q_next;

  // divider
  logic                           div_start, div_busy, div_done;
  logic [chs_pkg::SECTOR_W-1:0]   div_dvd, div_quo;
  logic [chs_pkg::PCYL_W-1:0]     div_dsr, div_rem;

  chs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // result register
  chs_pkg::res_t  res, out_res;
  logic           res_load, out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == chs_pkg::S_IDLE);

  logic [4:0]  heads_sel;
  logic [7:0]  spt_sel, room, burst;
  logic        tag_unit;

  always_comb begin
    heads_sel = (heads[act_unit] == '0) ? 5'd1 : heads[act_unit];
    spt_sel   = (spt_cfg[act_unit] == '0) ? 8'd1 : spt_cfg[act_unit];
    room      = spt_q - rem_q;
    burst     = (sectors_left > {8'd0, room}) ? room : sectors_left[7:0];
  end

  always_comb begin
    state_next        = state;
    active_next       = active;
    act_unit_next     = act_unit;
    act_write_next    = act_write;
    cur_sector_next   = cur_sector;
    sectors_left_next = sectors_left;
    burst_left_next   = burst_left;
    stray_total_next  = stray_total;
    soft_total_next   = soft_total;
    per_cyl_next      = per_cyl;
    spt_q_next        = spt_q;
    cyl_q_next        = cyl_q;
    trk_q_next        = trk_q;
    rem_q_next        = rem_q;
    div_start         = 1'b0;
    div_dvd           = cur_sector;
    div_dsr           = per_cyl;
    res               = '0;
    res_load          = 1'b0;
    tag_unit          = 1'b0;

    case (state)
      chs_pkg::S_IDLE: begin
        if (in_valid) state_next = chs_pkg::S_DECIDE;
      end

      chs_pkg::S_DECIDE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.last   = 1'b1;
          state_next = chs_pkg::S_IDLE;
          if (!r_action) begin
            if (active || !present[r_drive] || r_total == '0) begin
              res.kind = chs_pkg::K_REJECT;
            end else begin
              active_next       = 1'b1;
              act_unit_next     = r_drive;
              act_write_next    = r_write;
              cur_sector_next   = r_start;
              sectors_left_next = r_total;
              res.kind          = chs_pkg::K_ACCEPT;
              tag_unit          = 1'b1;
              res.last          = 1'b0;
              state_next        = chs_pkg::S_MUL;
            end
          end else if (r_busy || !active) begin
            if (stray_total != '1) stray_total_next = stray_total + 1'b1;
            res.kind = chs_pkg::K_STRAY;
          end else if (r_err) begin
            res.kind           = chs_pkg::K_DONE_ERR;
            tag_unit           = 1'b1;
            res.sector_address = cur_sector;
            active_next        = 1'b0;
          end else if (act_write && r_drq && burst_left == '0) begin
            // surplus data request on a write
            if (stray_total != '1) stray_total_next = stray_total + 1'b1;
            res.kind = chs_pkg::K_STRAY;
          end else begin
            if (r_ecc && soft_total != '1) soft_total_next = soft_total + 1'b1;
            if (act_write && !r_drq) begin
              // write burst finished, nothing emitted yet
              res_load   = 1'b0;
              state_next = chs_pkg::S_NEXT;
            end else begin
              res.kind           = chs_pkg::K_MOVE;
              tag_unit           = 1'b1;
              res.sector_address = cur_sector;
              cur_sector_next    = cur_sector + 1'b1;
              if (sectors_left != '0) sectors_left_next = sectors_left - 1'b1;
              if (burst_left != '0) burst_left_next = burst_left - 1'b1;
              if (!act_write && burst_left <= 8'd1) begin
                res.last   = 1'b0;
                state_next = chs_pkg::S_NEXT;
              end
            end
          end
        end
      end

      chs_pkg::S_NEXT: begin
        if (sectors_left != '0) begin
          state_next = chs_pkg::S_MUL;
        end else if (out_free) begin
          res_load           = 1'b1;
          res.kind           = chs_pkg::K_DONE_OK;
          tag_unit           = 1'b1;
          res.sector_address = cur_sector;
          res.last           = 1'b1;
          active_next        = 1'b0;
          state_next         = chs_pkg::S_IDLE;
        end
      end

      chs_pkg::S_MUL: begin
        per_cyl_next = chs_pkg::PCYL_W'(heads_sel) * chs_pkg::PCYL_W'(spt_sel);
        spt_q_next   = spt_sel;
        state_next   = chs_pkg::S_DIV1_GO;
      end

      chs_pkg::S_DIV1_GO: begin
        div_start  = 1'b1;
        state_next = chs_pkg::S_DIV1_WAIT;
      end

      chs_pkg::S_DIV1_WAIT: begin
        if (div_done) begin
          cyl_q_next = div_quo[15:0];
          div_start  = 1'b1;
          div_dvd    = chs_pkg::SECTOR_W'(div_rem);
          div_dsr    = chs_pkg::PCYL_W'(spt_q);
          state_next = chs_pkg::S_DIV2_WAIT;
        end
      end

      chs_pkg::S_DIV2_WAIT: begin
        if (div_done) begin
          trk_q_next = div_quo[3:0];
          rem_q_next = div_rem[7:0];
          state_next = chs_pkg::S_PROG;
        end
      end

      chs_pkg::S_PROG: begin
        if (out_free) begin
          res_load          = 1'b1;
          burst_left_next   = burst;
          res.kind          = chs_pkg::K_PROGRAM;
          tag_unit          = 1'b1;
          res.burst_count   = burst;
          res.sector_number = rem_q + 8'd1;
          res.cylinder      = cyl_q;
          res.head          = trk_q;
          res.last          = !act_write;
          state_next        = act_write ? chs_pkg::S_MOVE : chs_pkg::S_IDLE;
        end
      end

      chs_pkg::S_MOVE: begin
        if (out_free) begin
          res_load           = 1'b1;
          res.kind           = chs_pkg::K_MOVE;
          tag_unit           = 1'b1;
          res.sector_address = cur_sector;
          res.last           = 1'b1;
          cur_sector_next    = cur_sector + 1'b1;
          if (sectors_left != '0) sectors_left_next = sectors_left - 1'b1;
          if (burst_left != '0) burst_left_next = burst_left - 1'b1;
          state_next         = chs_pkg::S_IDLE;
        end
      end

      default: state_next = chs_pkg::S_IDLE;
    endcase

    if (tag_unit) begin
      res.unit_out      = act_unit_next;
      res.write_command = act_write_next;
    end
    res.stray_count      = stray_total_next;
    res.soft_error_count = soft_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chs_pkg::S_IDLE;
      active       <= 1'b0;
      act_unit     <= 1'b0;
      act_write    <= 1'b0;
      cur_sector   <= '0;
      sectors_left <= '0;
      burst_left   <= '0;
      stray_total  <= '0;
      soft_total   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      active       <= active_next;
      act_unit     <= act_unit_next;
      act_write    <= act_write_next;
      cur_sector   <= cur_sector_next;
      sectors_left <= sectors_left_next;
      burst_left   <= burst_left_next;
      stray_total  <= stray_total_next;
      soft_total   <= soft_total_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    per_cyl <= per_cyl_next;
    spt_q   <= spt_q_next;
    cyl_q   <= cyl_q_next;
    trk_q   <= trk_q_next;
    rem_q   <= rem_q_next;
    if (res_load) out_res <= res;
    if (in_valid && in_ready) begin
      r_action <= action;
      r_write  <= is_write;
      r_drive  <= drive;
      r_start  <= start_sector;
      r_total  <= sector_total;
      r_busy   <= status_busy;
      r_err    <= status_error;
      r_ecc    <= status_ecc;
      r_drq    <= status_drq;
    end
  end

  assign kind             = out_res.kind;
  assign burst_count      = out_res.burst_count;
  assign sector_number    = out_res.sector_number;
  assign cylinder         = out_res.cylinder;
  assign head             = out_res.head;
  assign unit_out         = out_res.unit_out;
  assign write_command    = out_res.write_command;
  assign sector_address   = out_res.sector_address;
  assign stray_count      = out_res.stray_count;
  assign soft_error_count = out_res.soft_error_count;
  assign last             = out_res.last;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == chs_pkg::S_IDLE |-> !div_busy)
    else $error("divider running while idle");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == chs_pkg::K_PROGRAM |-> out_res.burst_count != '0)
    else $error("empty burst programmed");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    $fell(active) |-> out_valid && out_res.last)
    else $error("transfer ended without a final result");

endmodule

`default_nettype wire
